FILE: rtl/cfv_pkg.sv
// Shared types, constants and the CRC-16 byte update for the CRC frame block.
// No dependencies; cfv_crc and crc16_frame_append_verify in rtl import this package.
`timescale 1ns / 1ps

package cfv_pkg;

    localparam int MAX_FRAME = 32;
    localparam int COUNT_W   = $clog2(MAX_FRAME + 1);
    localparam int ADDR_W    = $clog2(MAX_FRAME);

    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_TOP  = 16'h8000;
    localparam logic [15:0] CRC_POLY = 16'h1021;

    localparam logic MODE_APPEND = 1'b0;
    localparam logic MODE_VERIFY = 1'b1;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last;
    } byte_item_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       out_last;
        logic       check_ok;
        logic       overflow;
    } result_item_t;

    typedef enum logic [2:0] {
        ST_IN,
        ST_CRC_LO,
        ST_CRC_HI,
        ST_MSG,
        ST_VER
    } state_t;

    function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int k = 0; k < 8; k++)
        begin
            if ((c & CRC_TOP) != 16'h0000)
            begin
                c = {c[14:0], 1'b0} ^ CRC_POLY;
            end
            else
            begin
                c = {c[14:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

FILE: rtl/cfv_ram.sv
// Single-port-write, single-port-read synchronous RAM with registered read data.
// Generic; no package dependency.
`timescale 1ns / 1ps

module cfv_ram #(
    parameter int DEPTH = 32,
    parameter int WIDTH = 8
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

FILE: rtl/cfv_crc.sv
// CRC-16 accumulator register: one byte update per cycle, synchronous clear.
// Depends on cfv_pkg for the byte update function and the initial value.
`timescale 1ns / 1ps

module cfv_crc (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        clr,
    input  logic        upd,
    input  logic [7:0]  data_byte,
    output logic [15:0] crc
);

    import cfv_pkg::*;

    logic [15:0] crc_reg;
    logic [15:0] crc_next;

    always_comb
    begin
        crc_next = crc_reg;
        if (clr)
        begin
            crc_next = CRC_INIT;
        end
        else if (upd)
        begin
            crc_next = crc16_byte(crc_reg, data_byte);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            crc_reg <= CRC_INIT;
        end
        else
        begin
            crc_reg <= crc_next;
        end
    end

    assign crc = crc_reg;

endmodule

FILE: rtl/crc16_frame_append_verify.sv
// CRC-16 frame append / verify block. New bytes are taken only in ST_IN.
// Append mode: after the last byte, the CRC low byte, the CRC high byte, then the stored
// message bytes leave at one per cycle while result_ready is held high.
// Verify mode: one result item, registered out of ST_VER once the output slot is free.
// Reset (rst_n low, asynchronous) sets mode to append and clears the frame state;
// the message RAM is not cleared and needs no clearing pass.
`timescale 1ns / 1ps

module crc16_frame_append_verify (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  mode_we,
    input  logic                  mode_wdata,
    input  logic                  byte_valid,
    output logic                  byte_ready,
    input  cfv_pkg::byte_item_t   byte_item,
    output logic                  result_valid,
    input  logic                  result_ready,
    output cfv_pkg::result_item_t result_item
);

    import cfv_pkg::*;

    state_t              state_reg, state_next;
    logic                mode_reg, mode_next;
    logic [COUNT_W-1:0]  count_reg, count_next;
    logic [COUNT_W-1:0]  idx_reg, idx_next;
    logic [15:0]         stored_reg, stored_next;
    logic                ovf_reg, ovf_next;
    logic                out_valid_reg, out_valid_next;
    result_item_t        out_reg, out_next;

    logic                slot_free;
    logic                accept;
    logic                crc_clr, crc_upd;
    logic [15:0]         crc;
    logic                wr_en, rd_en;
    logic [ADDR_W-1:0]   rd_addr;
    logic [7:0]          rd_data;
    logic [COUNT_W-1:0]  idx_inc;

    cfv_crc u_crc (
        .clk       (clk),
        .rst_n     (rst_n),
        .clr       (crc_clr),
        .upd       (crc_upd),
        .data_byte (byte_item.data_byte),
        .crc       (crc)
    );

    cfv_ram #(
        .DEPTH (MAX_FRAME),
        .WIDTH (8)
    ) u_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (count_reg[ADDR_W-1:0]),
        .wr_data (byte_item.data_byte),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign byte_ready = (state_reg == ST_IN);
    assign accept     = byte_valid && byte_ready;
    assign slot_free  = !out_valid_reg || result_ready;
    assign idx_inc    = idx_reg + COUNT_W'(1);

    always_comb
    begin
        state_next     = state_reg;
        mode_next      = mode_reg;
        count_next     = count_reg;
        idx_next       = idx_reg;
        stored_next    = stored_reg;
        ovf_next       = ovf_reg;
        out_valid_next = out_valid_reg && !result_ready;
        out_next       = out_reg;
        crc_clr        = 1'b0;
        crc_upd        = 1'b0;
        wr_en          = 1'b0;
        rd_en          = 1'b0;
        rd_addr        = idx_inc[ADDR_W-1:0];

        unique case (state_reg)
            ST_IN:
            begin
                if (accept)
                begin
                    if (mode_reg == MODE_APPEND)
                    begin
                        if (count_reg < COUNT_W'(MAX_FRAME - 2))
                        begin
                            wr_en      = 1'b1;
                            crc_upd    = 1'b1;
                            count_next = count_reg + COUNT_W'(1);
                        end
                        else
                        begin
                            ovf_next = 1'b1;
                        end
                        if (byte_item.last)
                        begin
                            state_next = ST_CRC_LO;
                        end
                    end
                    else
                    begin
                        if (count_reg < COUNT_W'(MAX_FRAME))
                        begin
                            if (count_reg == COUNT_W'(0))
                            begin
                                stored_next = {8'h00, byte_item.data_byte};
                            end
                            else if (count_reg == COUNT_W'(1))
                            begin
                                stored_next = {byte_item.data_byte, stored_reg[7:0]};
                            end
                            else
                            begin
                                crc_upd = 1'b1;
                            end
                            count_next = count_reg + COUNT_W'(1);
                        end
                        else
                        begin
                            ovf_next = 1'b1;
                        end
                        if (byte_item.last)
                        begin
                            state_next = ST_VER;
                        end
                    end
                end
            end
            ST_CRC_LO:
            begin
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    out_next       = '{out_byte: crc[7:0],
                                       out_last: (count_reg == COUNT_W'(0)),
                                       check_ok: 1'b0,
                                       overflow: ovf_reg};
                    state_next     = ST_CRC_HI;
                end
            end
            ST_CRC_HI:
            begin
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    out_next       = '{out_byte: crc[15:8], out_last: 1'b0,
                                       check_ok: 1'b0, overflow: ovf_reg};
                    if (count_reg == COUNT_W'(0))
                    begin
                        crc_clr     = 1'b1;
                        count_next  = '0;
                        stored_next = '0;
                        ovf_next    = 1'b0;
                        state_next  = ST_IN;
                    end
                    else
                    begin
                        rd_en      = 1'b1;
                        rd_addr    = '0;
                        idx_next   = '0;
                        state_next = ST_MSG;
                    end
                end
            end
            ST_MSG:
            begin
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    out_next       = '{out_byte: rd_data,
                                       out_last: (idx_inc == count_reg),
                                       check_ok: 1'b0,
                                       overflow: ovf_reg};
                    if (idx_inc == count_reg)
                    begin
                        crc_clr     = 1'b1;
                        count_next  = '0;
                        stored_next = '0;
                        ovf_next    = 1'b0;
                        state_next  = ST_IN;
                    end
                    else
                    begin
                        rd_en    = 1'b1;
                        idx_next = idx_inc;
                    end
                end
            end
            ST_VER:
            begin
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    out_next       = '{out_byte: 8'h00, out_last: 1'b1,
                                       check_ok: (count_reg >= COUNT_W'(2))
                                                 && (stored_reg == crc),
                                       overflow: ovf_reg};
                    crc_clr        = 1'b1;
                    count_next     = '0;
                    stored_next    = '0;
                    ovf_next       = 1'b0;
                    state_next     = ST_IN;
                end
            end
            default:
            begin
                state_next = ST_IN;
            end
        endcase

        // clear the CRC, count, stored CRC and overflow of any frame in progress on a mode write; state is kept
        if (mode_we)
        begin
            mode_next   = mode_wdata;
            crc_clr     = 1'b1;
            crc_upd     = 1'b0;
            count_next  = '0;
            stored_next = '0;
            ovf_next    = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IN;
            mode_reg      <= MODE_APPEND;
            count_reg     <= '0;
            idx_reg       <= '0;
            stored_reg    <= '0;
            ovf_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            mode_reg      <= mode_next;
            count_reg     <= count_next;
            idx_reg       <= idx_next;
            stored_reg    <= stored_next;
            ovf_reg       <= ovf_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

    assign result_valid = out_valid_reg;
    assign result_item  = out_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= COUNT_W'(MAX_FRAME))
        else $error("byte count beyond frame capacity");

    a_idx_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_MSG) |-> (idx_reg < count_reg))
        else $error("replay index past stored message");

    a_ver_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_VER && slot_free && !mode_we)
            |=> (state_reg == ST_IN && count_reg == '0 && !ovf_reg && result_valid))
        else $error("verify result did not close the frame");

    a_write_only_append: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |-> (accept && mode_reg == MODE_APPEND))
        else $error("message store written outside an append transaction");

endmodule

FILE: tb/sv/testbench.sv
// Self-checking testbench for crc16_frame_append_verify: a directed table of frames, then
// random frames in both modes under varied valid/ready idling, checked against a local predictor.
// Depends on rtl/cfv_pkg.sv and rtl/crc16_frame_append_verify.sv.
`timescale 1ns / 1ps

module testbench;

    import cfv_pkg::*;

    localparam int QUIET_LIMIT = 2000;
    localparam int SETTLE_CYCLES = 6;

    typedef enum logic { ROW_BYTE, ROW_MODE } row_kind_t;

    typedef struct {
        row_kind_t    kind;
        logic         mode_val;
        logic [7:0]   data;
        logic         last;
        logic         typed;
        result_item_t want;
    } stim_row_t;

    logic         clk;
    logic         rst_n;
    logic         mode_we;
    logic         mode_wdata;
    logic         byte_valid;
    logic         byte_ready;
    byte_item_t   byte_item;
    logic         result_valid;
    logic         result_ready;
    result_item_t result_item;

    int send_idle_pct;
    int recv_idle_pct;
    int error_count;
    int quiet_cycles;

    result_item_t awaited_results[$];
    result_item_t want_item;
    stim_row_t    directed[$];

    logic        pred_mode;
    logic [15:0] pred_crc;
    logic [7:0]  pred_store [MAX_FRAME];
    int          pred_count;
    logic [15:0] pred_stored;
    logic        pred_ovf;

    crc16_frame_append_verify dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .mode_we      (mode_we),
        .mode_wdata   (mode_wdata),
        .byte_valid   (byte_valid),
        .byte_ready   (byte_ready),
        .byte_item    (byte_item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result_item  (result_item)
    );

    always #6 clk = ~clk;

    function automatic logic [15:0] crc16_next(input logic [15:0] c, input logic [7:0] d);
        logic fb;
        for (int i = 7; i >= 0; i--)
        begin
            fb = c[15] ^ d[i];
            c = {c[14:0], 1'b0};
            if (fb)
            begin
                c = c ^ CRC_POLY;
            end
        end
        return c;
    endfunction

    task automatic reset_frame_state();
        pred_crc    = CRC_INIT;
        pred_count  = 0;
        pred_stored = 16'h0000;
        pred_ovf    = 1'b0;
    endtask

    task automatic crc_frame_predict(input logic [7:0] d, input logic l);
        if (pred_mode == MODE_APPEND)
        begin
            if (pred_count < MAX_FRAME - 2)
            begin
                pred_store[pred_count] = d;
                pred_count++;
                pred_crc = crc16_next(pred_crc, d);
            end
            else
            begin
                pred_ovf = 1'b1;
            end
            if (l)
            begin
                awaited_results.push_back('{pred_crc[7:0], pred_count == 0, 1'b0, pred_ovf});
                awaited_results.push_back('{pred_crc[15:8], 1'b0, 1'b0, pred_ovf});
                for (int i = 0; i < pred_count; i++)
                begin
                    awaited_results.push_back('{pred_store[i], i + 1 == pred_count, 1'b0,
                                                pred_ovf});
                end
                reset_frame_state();
            end
        end
        else
        begin
            if (pred_count < MAX_FRAME)
            begin
                if (pred_count == 0)
                begin
                    pred_stored = {8'h00, d};
                end
                else if (pred_count == 1)
                begin
                    pred_stored[15:8] = d;
                end
                else
                begin
                    pred_crc = crc16_next(pred_crc, d);
                end
                pred_count++;
            end
            else
            begin
                pred_ovf = 1'b1;
            end
            if (l)
            begin
                awaited_results.push_back('{8'h00, 1'b1,
                                            pred_count >= 2 && pred_stored == pred_crc,
                                            pred_ovf});
                reset_frame_state();
            end
        end
    endtask

    task automatic send_byte(input logic [7:0] d, input logic l);
        while ($urandom_range(99) < send_idle_pct)
        begin
            byte_valid <= 1'b0;
            @(posedge clk);
        end
        byte_valid <= 1'b1;
        byte_item  <= '{data_byte: d, last: l};
        do
            @(posedge clk);
        while (byte_ready !== 1'b1);
        crc_frame_predict(d, l);
    endtask

    task automatic drain_results();
        byte_valid <= 1'b0;
        while (awaited_results.size() != 0)
        begin
            @(posedge clk);
        end
        @(posedge clk);
    endtask

    task automatic write_mode(input logic v);
        drain_results();
        repeat (SETTLE_CYCLES) @(posedge clk);
        mode_we    <= 1'b1;
        mode_wdata <= v;
        @(posedge clk);
        mode_we <= 1'b0;
        pred_mode = v;
        reset_frame_state();
    endtask

    // Verify frames mostly carry a correct CRC over the bytes the block keeps.
    task automatic send_frame(input int len);
        logic [7:0]  body[$];
        logic [15:0] c;
        c = CRC_INIT;
        for (int i = 0; i < len; i++)
        begin
            body.push_back(8'($urandom_range(255)));
        end
        if (pred_mode == MODE_VERIFY && len >= 2 && $urandom_range(9) != 0)
        begin
            for (int i = 2; i < len && i < MAX_FRAME; i++)
            begin
                c = crc16_next(c, body[i]);
            end
            if ($urandom_range(4) == 0)
            begin
                c = c ^ (16'h0001 << $urandom_range(15));
            end
            body[0] = c[7:0];
            body[1] = c[15:8];
        end
        foreach (body[i])
        begin
            send_byte(body[i], i == body.size() - 1);
        end
    endtask

    task automatic report(input string field, input int exp_val, input int got_val);
        error_count++;
        $display("%0t: %s mismatch: expected %0h actual %0h", $time, field, exp_val, got_val);
    endtask

    always @(posedge clk)
    begin
        result_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n && result_valid && result_ready)
        begin
            if (awaited_results.size() == 0)
            begin
                error_count++;
                $display("%0t: unexpected result: expected none actual %p", $time, result_item);
            end
            else
            begin
                want_item = awaited_results.pop_front();
                if (result_item.out_byte !== want_item.out_byte)
                begin
                    report("out_byte", want_item.out_byte, result_item.out_byte);
                end
                if (result_item.out_last !== want_item.out_last)
                begin
                    report("out_last", want_item.out_last, result_item.out_last);
                end
                if (result_item.check_ok !== want_item.check_ok)
                begin
                    report("check_ok", want_item.check_ok, result_item.check_ok);
                end
                if (result_item.overflow !== want_item.overflow)
                begin
                    report("overflow", want_item.overflow, result_item.overflow);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((byte_valid && byte_ready) || (result_valid && result_ready) || mode_we)
        begin
            quiet_cycles <= 0;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles + 1 >= QUIET_LIMIT)
            begin
                $display("Testbench completed WITH ERRORS");
                $finish;
            end
        end
    end

    initial
    begin
        int seg_items;
        int len;
        bit long_done;

        clk           = 1'b0;
        rst_n         = 1'b0;
        mode_we       = 1'b0;
        mode_wdata    = 1'b0;
        byte_valid    = 1'b0;
        byte_item     = '0;
        result_ready  = 1'b0;
        error_count   = 0;
        quiet_cycles  = 0;
        send_idle_pct = 20;
        recv_idle_pct = 62;
        pred_mode     = MODE_APPEND;
        reset_frame_state();

        // append after reset: a one-byte frame of 0x00, then a two-byte frame of 0xFF, 0x80
        directed.push_back('{ROW_BYTE, MODE_APPEND, 8'h00, 1'b1, 1'b0, '0});
        directed.push_back('{ROW_BYTE, MODE_APPEND, 8'hFF, 1'b0, 1'b0, '0});
        directed.push_back('{ROW_BYTE, MODE_APPEND, 8'h80, 1'b1, 1'b0, '0});
        directed.push_back('{ROW_MODE, MODE_VERIFY, 8'h00, 1'b0, 1'b0, '0});
        // short verify frame always fails
        directed.push_back('{ROW_BYTE, MODE_APPEND, 8'hAA, 1'b1, 1'b1,
                             '{8'h00, 1'b1, 1'b0, 1'b0}});
        // no message: computed CRC stays at its initial value
        directed.push_back('{ROW_BYTE, MODE_APPEND, 8'hFF, 1'b0, 1'b0, '0});
        directed.push_back('{ROW_BYTE, MODE_APPEND, 8'hFF, 1'b1, 1'b1,
                             '{8'h00, 1'b1, 1'b1, 1'b0}});
        directed.push_back('{ROW_BYTE, MODE_APPEND, 8'h00, 1'b0, 1'b0, '0});
        directed.push_back('{ROW_BYTE, MODE_APPEND, 8'h00, 1'b1, 1'b1,
                             '{8'h00, 1'b1, 1'b0, 1'b0}});
        // standard check string "123456789" with its CRC 0x29B1
        directed.push_back('{ROW_BYTE, MODE_APPEND, 8'hB1, 1'b0, 1'b0, '0});
        directed.push_back('{ROW_BYTE, MODE_APPEND, 8'h29, 1'b0, 1'b0, '0});
        for (int i = 1; i <= 9; i++)
        begin
            directed.push_back('{ROW_BYTE, MODE_APPEND, 8'h30 + 8'(i), i == 9, i == 9,
                                 '{8'h00, 1'b1, 1'b1, 1'b0}});
        end
        // mode write abandons a frame in progress
        directed.push_back('{ROW_BYTE, MODE_APPEND, 8'h12, 1'b0, 1'b0, '0});
        directed.push_back('{ROW_BYTE, MODE_APPEND, 8'h34, 1'b0, 1'b0, '0});
        directed.push_back('{ROW_MODE, MODE_APPEND, 8'h00, 1'b0, 1'b0, '0});
        directed.push_back('{ROW_BYTE, MODE_APPEND, 8'h5A, 1'b1, 1'b0, '0});

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed[i])
        begin
            if (directed[i].kind == ROW_MODE)
            begin
                write_mode(directed[i].mode_val);
            end
            else
            begin
                send_byte(directed[i].data, directed[i].last);
                if (directed[i].typed)
                begin
                    void'(awaited_results.pop_back());
                    awaited_results.push_back(directed[i].want);
                end
            end
        end

        for (int phase = 0; phase < 3; phase++)
        begin
            send_idle_pct = (phase == 0) ? 20 : (phase == 1) ? 62 : 0;
            recv_idle_pct = (phase == 0) ? 62 : (phase == 1) ? 20 : 0;
            for (int m = 0; m < 2; m++)
            begin
                write_mode(m == 0 ? MODE_APPEND : MODE_VERIFY);
                seg_items = 0;
                long_done = 1'b0;
                while (seg_items < 56)
                begin
                    if (!long_done && ($urandom_range(3) == 0 || seg_items > 35))
                    begin
                        len = $urandom_range(MAX_FRAME + 4, MAX_FRAME - 3);
                        long_done = 1'b1;
                    end
                    else
                    begin
                        len = $urandom_range(12, 1);
                    end
                    send_frame(len);
                    seg_items += len;
                    if ($urandom_range(19) == 0)
                    begin
                        drain_results();
                    end
                end
            end
        end

        drain_results();
        repeat (SETTLE_CYCLES + 2) @(posedge clk);
        if (error_count == 0 && awaited_results.size() == 0)
        begin
            $display("Testbench completed without errors");
        end
        else
        begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
